@@ sv/sba_pkg.sv @@
// ----------------------------------------------------------------------------
// sba_pkg
// Types and constants shared by the scaled alpha-over blitter.
// ----------------------------------------------------------------------------
package sba_pkg;

    localparam int STORE_DEPTH = 4096;
    localparam int STORE_AW    = 12;
    localparam int QUOT_BITS   = 7;
    localparam int PROD_W      = 20;

    typedef enum logic [3:0] {
        REG_SRC_LEFT = 4'd0,
        REG_SRC_TOP  = 4'd1,
        REG_SRC_COLS = 4'd2,
        REG_SRC_ROWS = 4'd3,
        REG_DST_LEFT = 4'd4,
        REG_DST_TOP  = 4'd5,
        REG_DST_COLS = 4'd6,
        REG_DST_ROWS = 4'd7
    } reg_index_t;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    localparam logic [0:0] ACTION_LOAD = 1'b0;
    localparam logic [0:0] ACTION_DRAW = 1'b1;

    typedef struct packed {
        logic [0:0]  action;
        logic [11:0] image_index;
        logic [31:0] image_word;
        logic [11:0] canvas_col;
        logic [11:0] canvas_row;
        logic [31:0] canvas_word;
    } item_t;

    typedef struct packed {
        logic [31:0] out_word;
        logic [1:0]  status;
    } result_t;

    // Context that travels with each word down the pipeline.
    typedef struct packed {
        logic [0:0]  action;
        logic        blend;
        logic [1:0]  status;
        logic [11:0] image_index;
        logic [31:0] image_word;
        logic [31:0] canvas_word;
    } ctx_t;

    typedef struct packed {
        logic [PROD_W-1:0]    rem_x;
        logic [PROD_W-1:0]    rem_y;
        logic [QUOT_BITS-1:0] q_x;
        logic [QUOT_BITS-1:0] q_y;
    } div_t;

endpackage

@@ sv/scaled_blit_alpha_over.sv @@
// ----------------------------------------------------------------------------
// scaled_blit_alpha_over
// Nearest-neighbor scaled blit of a stored source image, composited over
// canvas pixels with premultiplied alpha.
// ----------------------------------------------------------------------------
// Channel   Handshake              Word
// input     start (busy is low)    item   : item_t
// result    done strobe            result : result_t
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word is accepted every cycle; busy stays low. Each result passes through
// the seven compare-subtract stages of the two scale dividers plus address,
// store read and blend stages before done is raised.
// Reset clears all valid bits and sets the configuration registers to their defaults; the image
// store holds no reset value. The result side cannot stall.
// ----------------------------------------------------------------------------
module scaled_blit_alpha_over #(
    parameter int IMAGE_WIDTH  = 64,
    parameter int IMAGE_HEIGHT = 64,
    parameter int CANVAS_LIMIT = 4096
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  sba_pkg::item_t  item,
    output logic            done,
    output sba_pkg::result_t result,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [3:0]      cfg_index,
    input  logic [12:0]     cfg_data
);
    import sba_pkg::*;

    // Configuration registers.
    logic [5:0]  src_left_reg, src_top_reg;
    logic [6:0]  src_cols_reg, src_rows_reg;
    logic [12:0] dst_left_reg, dst_top_reg, dst_cols_reg, dst_rows_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            src_left_reg <= '0;
            src_top_reg  <= '0;
            src_cols_reg <= 7'd1;
            src_rows_reg <= 7'd1;
            dst_left_reg <= '0;
            dst_top_reg  <= '0;
            dst_cols_reg <= 13'd1;
            dst_rows_reg <= 13'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_index_t'(cfg_index))
                REG_SRC_LEFT: src_left_reg <= cfg_data[5:0];
                REG_SRC_TOP:  src_top_reg  <= cfg_data[5:0];
                REG_SRC_COLS: src_cols_reg <= cfg_data[6:0];
                REG_SRC_ROWS: src_rows_reg <= cfg_data[6:0];
                REG_DST_LEFT: dst_left_reg <= cfg_data;
                REG_DST_TOP:  dst_top_reg  <= cfg_data;
                REG_DST_COLS: dst_cols_reg <= cfg_data;
                REG_DST_ROWS: dst_rows_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- Stage 0: classify and offset ----------------
    logic               take;
    logic               rect_bad, outside;
    logic signed [13:0] dx_s, dy_s;
    logic [12:0]        sum_w, sum_h;
    ctx_t               ctx0_next;

    assign take  = start && !busy;
    assign sum_w = 13'(src_left_reg) + 13'(src_cols_reg);
    assign sum_h = 13'(src_top_reg) + 13'(src_rows_reg);
    assign dx_s  = $signed({2'b00, item.canvas_col}) - $signed({dst_left_reg[12], dst_left_reg});
    assign dy_s  = $signed({2'b00, item.canvas_row}) - $signed({dst_top_reg[12], dst_top_reg});

    always_comb
    begin
        rect_bad = (src_cols_reg == '0) || (src_rows_reg == '0) ||
                   (dst_cols_reg == '0) || (dst_rows_reg == '0) ||
                   (17'(sum_w) > 17'(IMAGE_WIDTH)) || (17'(sum_h) > 17'(IMAGE_HEIGHT));
        outside  = (17'(item.canvas_col) >= 17'(CANVAS_LIMIT)) ||
                   (17'(item.canvas_row) >= 17'(CANVAS_LIMIT)) ||
                   dx_s[13] || dy_s[13] ||
                   (dx_s[12:0] >= dst_cols_reg) || (dy_s[12:0] >= dst_rows_reg);
        ctx0_next.action      = item.action;
        ctx0_next.image_index = item.image_index;
        ctx0_next.image_word  = item.image_word;
        ctx0_next.canvas_word = item.canvas_word;
        ctx0_next.blend       = 1'b0;
        if (item.action == ACTION_LOAD)
            ctx0_next.status = STATUS_OK;
        else if (rect_bad)
            ctx0_next.status = STATUS_INVALID;
        else if (outside)
            ctx0_next.status = STATUS_OUTSIDE;
        else
        begin
            ctx0_next.status = STATUS_OK;
            ctx0_next.blend  = 1'b1;
        end
    end

    logic        v0_reg;
    ctx_t        ctx0_reg;
    logic [12:0] dx0_reg, dy0_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= take;
    end

    always_ff @(posedge clk) begin
        ctx0_reg <= ctx0_next;
        dx0_reg  <= dx_s[12:0];
        dy0_reg  <= dy_s[12:0];
    end

    // ---------------- Stage 1: scale products ----------------
    logic  v1_reg;
    ctx_t  ctx1_reg;
    div_t  div1_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk) begin
        ctx1_reg       <= ctx0_reg;
        div1_reg.rem_x <= PROD_W'(dx0_reg) * PROD_W'(src_cols_reg);
        div1_reg.rem_y <= PROD_W'(dy0_reg) * PROD_W'(src_rows_reg);
        div1_reg.q_x   <= '0;
        div1_reg.q_y   <= '0;
    end

    // ---------------- Stages 2..8: restoring division, one bit each ----------
    logic [QUOT_BITS:1] vd_reg;
    ctx_t               ctxd_reg [1:QUOT_BITS];
    div_t               divd_reg [1:QUOT_BITS];

    for (genvar k = 0; k < QUOT_BITS; k++) begin : g_div
        localparam int SH = QUOT_BITS - 1 - k;
        logic [PROD_W-1:0] den_x, den_y;
        div_t              div_next;
        logic              v_in;
        ctx_t              ctx_in;
        div_t              div_in;

        if (k == 0) begin : g_first
            assign v_in   = v1_reg;
            assign ctx_in = ctx1_reg;
            assign div_in = div1_reg;
        end
        else begin : g_next
            assign v_in   = vd_reg[k];
            assign ctx_in = ctxd_reg[k];
            assign div_in = divd_reg[k];
        end

        assign den_x = PROD_W'(dst_cols_reg) << SH;
        assign den_y = PROD_W'(dst_rows_reg) << SH;

        always_comb
        begin
            div_next = div_in;
            if (div_in.rem_x >= den_x)
            begin
                div_next.rem_x   = div_in.rem_x - den_x;
                div_next.q_x[SH] = 1'b1;
            end
            if (div_in.rem_y >= den_y)
            begin
                div_next.rem_y   = div_in.rem_y - den_y;
                div_next.q_y[SH] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n)
                vd_reg[k+1] <= 1'b0;
            else
                vd_reg[k+1] <= v_in;
        end

        always_ff @(posedge clk) begin
            ctxd_reg[k+1] <= ctx_in;
            divd_reg[k+1] <= div_next;
        end
    end

    // ---------------- Stage 9: store address ----------------
    logic [7:0]          sx, sy;
    logic [PROD_W-1:0]   addr_full;
    logic                va_reg;
    ctx_t                ctxa_reg;
    logic [STORE_AW-1:0] addr_reg;

    assign sx        = 8'(src_left_reg) + 8'(divd_reg[QUOT_BITS].q_x);
    assign sy        = 8'(src_top_reg) + 8'(divd_reg[QUOT_BITS].q_y);
    assign addr_full = PROD_W'(sy) * PROD_W'(IMAGE_WIDTH) + PROD_W'(sx);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            va_reg <= 1'b0;
        else
            va_reg <= vd_reg[QUOT_BITS];
    end

    always_ff @(posedge clk) begin
        ctxa_reg <= ctxd_reg[QUOT_BITS];
        addr_reg <= addr_full[STORE_AW-1:0];
    end

    // ---------------- Stage 10: image store ----------------
    // Loads write in the same stage where draws read, so every draw sees
    // exactly the loads that were accepted before it.
    logic [31:0] image_mem [STORE_DEPTH];
    logic [31:0] src_word_reg;
    logic        vm_reg;
    ctx_t        ctxm_reg;

    always_ff @(posedge clk) begin
        if (va_reg && ctxa_reg.action == ACTION_LOAD)
            image_mem[ctxa_reg.image_index] <= ctxa_reg.image_word;
        src_word_reg <= image_mem[addr_reg];
        ctxm_reg     <= ctxa_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            vm_reg <= 1'b0;
        else
            vm_reg <= va_reg;
    end

    // ---------------- Stage 11: destination times inverse alpha ----------
    logic [7:0]  inv_a;
    logic [15:0] prod_next [3];
    logic [15:0] prod_reg  [3];
    logic [7:0]  src_ch_reg [3];
    logic        vb_reg;
    ctx_t        ctxb_reg;

    assign inv_a = 8'hFF - src_word_reg[31:24];

    for (genvar c = 0; c < 3; c++) begin : g_mul
        assign prod_next[c] = 16'(ctxm_reg.canvas_word[8*c +: 8]) * 16'(inv_a) + 16'd127;
        always_ff @(posedge clk) begin
            prod_reg[c]   <= prod_next[c];
            src_ch_reg[c] <= src_word_reg[8*c +: 8];
        end
    end

    always_ff @(posedge clk) begin
        ctxb_reg <= ctxm_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else
            vb_reg <= vm_reg;
    end

    // ---------------- Stage 12: divide by 255, add, saturate ----------
    // floor(p / 255) equals (p + (p >> 8) + 1) >> 8 for every p below 65535.
    logic [7:0]  chan [3];
    logic [31:0] blended;
    result_t     result_next;

    for (genvar c = 0; c < 3; c++) begin : g_chan
        logic [16:0] q_w;
        logic [8:0]  sum;
        assign q_w     = (17'(prod_reg[c]) + 17'(prod_reg[c][15:8]) + 17'd1) >> 8;
        assign sum     = 9'(src_ch_reg[c]) + 9'(q_w[7:0]);
        assign chan[c] = sum[8] ? 8'hFF : sum[7:0];
    end

    assign blended = {8'h00, chan[2], chan[1], chan[0]};

    always_comb
    begin
        result_next.status = ctxb_reg.status;
        if (ctxb_reg.action == ACTION_LOAD)
            result_next.out_word = '0;
        else if (ctxb_reg.blend)
            result_next.out_word = blended;
        else
            result_next.out_word = ctxb_reg.canvas_word;
    end

    logic    done_reg;
    result_t result_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vb_reg;
    end

    always_ff @(posedge clk) begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ---------------- Assertions ----------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> ##13 done)
        else $error("result did not appear at the expected latency");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == STATUS_OK || result.status == STATUS_OUTSIDE ||
                  result.status == STATUS_INVALID))
        else $error("result status out of range");

    a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
        (vb_reg && ctxb_reg.action == ACTION_LOAD) |=>
            (done && result.out_word == '0 && result.status == STATUS_OK))
        else $error("load word did not give a clean result");

    a_blend_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (vb_reg && ctxb_reg.blend) |=> (result.out_word[31:24] == 8'h00))
        else $error("blended word carries a nonzero alpha byte");

endmodule
